@@ src/tct_pkg.sv @@
package tct_pkg;

    // parse contexts
    localparam logic [3:0] C_NONE        = 4'd0;
    localparam logic [3:0] C_SOL_OR_NAME = 4'd1;
    localparam logic [3:0] C_TAG_NAME    = 4'd2;
    localparam logic [3:0] C_TAG         = 4'd3;
    localparam logic [3:0] C_ATTR_NAME   = 4'd4;
    localparam logic [3:0] C_WS_OR_EQ    = 4'd5;
    localparam logic [3:0] C_WS_OR_VAL   = 4'd6;
    localparam logic [3:0] C_QVAL        = 4'd7;
    localparam logic [3:0] C_UVAL        = 4'd8;
    localparam logic [3:0] C_TAG_END     = 4'd9;
    localparam logic [3:0] C_COMMENT     = 4'd10;
    localparam logic [3:0] C_CDATA       = 4'd11;
    localparam logic [3:0] C_RAW_NONE    = 4'd12;

    // token kinds
    localparam logic [4:0] K_TEXT      = 5'd0;
    localparam logic [4:0] K_WS        = 5'd1;
    localparam logic [4:0] K_COM_START = 5'd2;
    localparam logic [4:0] K_COM_END   = 5'd3;
    localparam logic [4:0] K_CD_START  = 5'd4;
    localparam logic [4:0] K_CD_END    = 5'd5;
    localparam logic [4:0] K_TAG_START = 5'd6;
    localparam logic [4:0] K_TAG_NAME  = 5'd7;
    localparam logic [4:0] K_SOLIDUS   = 5'd8;
    localparam logic [4:0] K_TAG_CLOSE = 5'd9;
    localparam logic [4:0] K_ATTR_NAME = 5'd10;
    localparam logic [4:0] K_EQUAL     = 5'd11;
    localparam logic [4:0] K_Q_START   = 5'd12;
    localparam logic [4:0] K_Q_VALUE   = 5'd13;
    localparam logic [4:0] K_Q_END     = 5'd14;
    localparam logic [4:0] K_U_VALUE   = 5'd15;
    localparam logic [4:0] K_OTHER     = 5'd16;

    // span slots
    localparam logic [2:0] S_TAG     = 3'd0;
    localparam logic [2:0] S_ANAME   = 3'd1;
    localparam logic [2:0] S_AVAL    = 3'd2;
    localparam logic [2:0] S_COMMENT = 3'd3;
    localparam logic [2:0] S_CDATA   = 3'd4;
    localparam logic [2:0] S_RAW     = 3'd5;
    localparam int         N_SPANS   = 6;

    localparam logic [1:0] T_COMMENT = 2'd0;
    localparam logic [1:0] T_CDATA   = 2'd1;
    localparam logic [1:0] T_RAW     = 2'd2;

    localparam int MAX_PASSES = 4;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic        rawtext_mode;
    } t_tok_in;

    typedef struct packed {
        logic [3:0]  context_code;
        logic [1:0]  tag_flags;
        logic [5:0]  span_valid_mask;
        logic [31:0] tag_name_start;
        logic [31:0] tag_name_length;
        logic [31:0] attr_name_start;
        logic [31:0] attr_name_length;
        logic [31:0] attr_value_start;
        logic [31:0] attr_value_length;
        logic [1:0]  text_kind;
        logic [31:0] text_start;
        logic [31:0] text_length;
    } t_res;

    // classified token, positions travel beside it
    typedef struct packed {
        logic [4:0] kind;
        logic       raw;
    } t_tok_cls;

    // narrow state carried through the dispatch chain
    typedef struct packed {
        logic [3:0] ctx;
        logic       sc;
        logic       qf;
        logic       vu;
        logic [1:0] ltk;
        logic [5:0] inval;
        logic       grow_en;
        logic [2:0] grow_sel;
        logic       grow_same;
    } t_ctx_st;

    typedef struct packed {
        t_ctx_st st;
        logic    again;
    } t_pass;

    function automatic t_ctx_st tct_grow(t_ctx_st st, logic [2:0] s, logic same);
        t_ctx_st r;
        r           = st;
        r.grow_en   = 1'b1;
        r.grow_sel  = s;
        r.grow_same = same;
        if (s >= S_COMMENT) begin
            r.ltk = 2'(s - S_COMMENT);
        end
        return r;
    endfunction

    // one dispatch pass of the context machine
    function automatic t_pass tct_pass(t_ctx_st st, logic [4:0] k, logic raw);
        t_pass r;
        r.st    = st;
        r.again = 1'b0;
        case (st.ctx)
            C_SOL_OR_NAME: begin
                if (k == K_SOLIDUS) begin
                    r.st.ctx = C_TAG_NAME;
                end else begin
                    r.st.ctx = (k == K_TAG_NAME) ? C_TAG_NAME : C_TAG;
                    r.again  = 1'b1;
                end
            end
            C_TAG_NAME: begin
                if (k == K_TAG_NAME) begin
                    r.st = tct_grow(st, S_TAG, 1'b1);
                end else if (k == K_WS) begin
                    r.st.ctx = C_TAG;
                end else if (k == K_TAG_CLOSE) begin
                    r.st.ctx = C_NONE;
                end else begin
                    r.st.ctx = C_TAG;
                    r.again  = 1'b1;
                end
            end
            C_TAG: begin
                if (k == K_TAG_CLOSE) begin
                    r.st.ctx = C_NONE;
                end else if (k == K_SOLIDUS) begin
                    r.st.ctx = C_TAG_END;
                end else if (k == K_ATTR_NAME) begin
                    r.st.ctx = C_ATTR_NAME;
                    r.st.inval[S_ANAME] = 1'b1;
                    r.st.inval[S_AVAL]  = 1'b1;
                    r.st.qf  = 1'b0;
                    r.again  = 1'b1;
                end else if (k == K_Q_START) begin
                    r.st.ctx = C_QVAL;
                    r.st.inval[S_ANAME] = 1'b1;
                    r.st.inval[S_AVAL]  = 1'b1;
                    r.st.qf  = 1'b1;
                end
            end
            C_ATTR_NAME: begin
                if (k == K_ATTR_NAME) begin
                    r.st = tct_grow(st, S_ANAME, 1'b1);
                end else if (k == K_EQUAL) begin
                    r.st.ctx = C_WS_OR_VAL;
                end else begin
                    r.st.ctx = (k == K_WS) ? C_WS_OR_EQ : C_TAG;
                    r.again  = 1'b1;
                end
            end
            C_WS_OR_EQ: begin
                if (k == K_EQUAL) begin
                    r.st.ctx = C_WS_OR_VAL;
                end else if (k != K_WS) begin
                    r.st.ctx = C_TAG;
                    r.again  = 1'b1;
                end
            end
            C_WS_OR_VAL: begin
                if (k == K_Q_START) begin
                    r.st.ctx = C_QVAL;
                    r.st.qf  = 1'b1;
                end else if (k != K_WS) begin
                    r.st.ctx = (k == K_U_VALUE) ? C_UVAL : C_TAG;
                    r.again  = 1'b1;
                end
            end
            C_QVAL: begin
                if (k == K_Q_VALUE) begin
                    r.st    = tct_grow(st, S_AVAL, !st.vu);
                    r.st.vu = 1'b0;
                end else begin
                    r.st.ctx = C_TAG;
                    r.again  = (k != K_Q_END);
                end
            end
            C_UVAL: begin
                if (k == K_U_VALUE) begin
                    r.st    = tct_grow(st, S_AVAL, st.vu);
                    r.st.vu = 1'b1;
                end else begin
                    r.st.ctx = C_TAG;
                    r.again  = 1'b1;
                end
            end
            C_TAG_END: begin
                if (k == K_TAG_CLOSE) begin
                    r.st.sc  = 1'b1;
                    r.st.ctx = C_NONE;
                end else begin
                    r.st.ctx = C_TAG;
                    r.again  = 1'b1;
                end
            end
            C_CDATA: begin
                if (k == K_CD_END) begin
                    r.st.ctx = C_NONE;
                end else if (k == K_TEXT) begin
                    r.st = tct_grow(st, S_CDATA, 1'b1);
                end
            end
            C_COMMENT: begin
                if (k == K_COM_END) begin
                    r.st.ctx = C_NONE;
                end else if (k == K_TEXT) begin
                    r.st = tct_grow(st, S_COMMENT, 1'b1);
                end
            end
            default: begin
                r.st.ctx = C_NONE;
                if (raw && k == K_TEXT) begin
                    r.st = tct_grow(r.st, S_RAW, 1'b1);
                end else if (k == K_TAG_START) begin
                    r.st.sc  = 1'b0;
                    r.st.ctx = C_SOL_OR_NAME;
                    r.st.inval[S_TAG] = 1'b1;
                end else if (k == K_COM_START) begin
                    r.st.ctx = C_COMMENT;
                    r.st.inval[S_COMMENT] = 1'b1;
                    r.st.ltk = T_COMMENT;
                end else if (k == K_CD_START) begin
                    r.st.ctx = C_CDATA;
                    r.st.inval[S_CDATA] = 1'b1;
                    r.st.ltk = T_CDATA;
                end
            end
        endcase
        return r;
    endfunction

endpackage

@@ src/tct_front.sv @@
module tct_front import tct_pkg::*; #(
    parameter int POS_WIDTH = 32
) (
    input  t_tok_in                i_tok,
    output t_tok_cls               o_cls,
    output logic [POS_WIDTH-1:0]   o_pos,
    output logic [POS_WIDTH-1:0]   o_len
);

    // unknown kinds fold onto "other"
    always_comb begin
        o_cls.kind = (i_tok.token_kind > K_OTHER) ? K_OTHER : i_tok.token_kind;
        o_cls.raw  = i_tok.rawtext_mode;
    end

    assign o_pos = POS_WIDTH'(i_tok.token_start);
    assign o_len = POS_WIDTH'(i_tok.token_length);

endmodule

@@ src/tct_fifo.sv @@
module tct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/tct_back.sv @@
module tct_back import tct_pkg::*; #(
    parameter int POS_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tok_valid,
    output logic                 o_tok_ready,
    input  t_tok_cls             i_cls,
    input  logic [POS_WIDTH-1:0] i_pos,
    input  logic [POS_WIDTH-1:0] i_len,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_res                 o_res
);

    logic [3:0]           r_ctx;
    logic                 r_sc;
    logic                 r_qf;
    logic                 r_vu;
    logic [1:0]           r_ltk;
    logic [5:0]           r_valid;
    logic [POS_WIDTH-1:0] r_begin [N_SPANS];
    logic [POS_WIDTH-1:0] r_size  [N_SPANS];
    logic                 r_out_valid;
    t_res                 r_res;

    logic [5:0]           n_valid;
    logic [POS_WIDTH-1:0] n_begin [N_SPANS];
    logic [POS_WIDTH-1:0] n_size  [N_SPANS];
    t_res                 n_res;

    t_ctx_st              st;
    logic                 tok_take;
    logic [5:0]           valid_mid;
    logic [POS_WIDTH-1:0] g_begin;
    logic [POS_WIDTH-1:0] g_size;
    logic [POS_WIDTH-1:0] g_end;
    logic [POS_WIDTH:0]   g_sum;
    logic                 g_restart;
    logic [1:0]           tk;
    logic [2:0]           tsel;

    assign o_tok_ready = !r_out_valid || i_ready;
    assign tok_take    = i_tok_valid && o_tok_ready;
    assign o_valid     = r_out_valid;
    assign o_res       = r_res;

    // bounded re-dispatch, unrolled
    always_comb begin
        t_ctx_st s;
        t_pass   p;
        logic    again;
        s       = '0;
        s.ctx   = r_ctx;
        s.sc    = r_sc;
        s.qf    = r_qf;
        s.vu    = r_vu;
        s.ltk   = r_ltk;
        again   = 1'b1;
        for (int n = 0; n < MAX_PASSES; n++) begin
            if (again) begin
                p     = tct_pass(s, i_cls.kind, i_cls.raw);
                s     = p.st;
                again = p.again;
            end
        end
        st = s;
    end

    // shared adders for the span being grown: end check and length sum
    always_comb begin
        valid_mid = r_valid & ~st.inval;
        g_begin   = r_begin[st.grow_sel];
        g_size    = r_size[st.grow_sel];
        g_end     = g_begin + g_size;
        g_sum     = {1'b0, g_size} + {1'b0, i_len};
        g_restart = !valid_mid[st.grow_sel] || !st.grow_same || (g_end != i_pos);
        n_valid   = valid_mid;
        for (int i = 0; i < N_SPANS; i++) begin
            n_begin[i] = r_begin[i];
            n_size[i]  = r_size[i];
        end
        if (st.grow_en) begin
            n_valid[st.grow_sel] = 1'b1;
            if (g_restart) begin
                n_begin[st.grow_sel] = i_pos;
                n_size[st.grow_sel]  = i_len;
            end else begin
                n_size[st.grow_sel] = g_sum[POS_WIDTH] ? '1 : g_sum[POS_WIDTH-1:0];
            end
        end
    end

    // snapshot of the state after this token
    always_comb begin
        tk   = (st.ltk > T_RAW) ? T_COMMENT : st.ltk;
        tsel = S_COMMENT + 3'(tk);
        n_res.context_code    = (st.ctx == C_NONE && i_cls.raw) ? C_RAW_NONE : st.ctx;
        n_res.tag_flags       = {st.qf, st.sc};
        n_res.span_valid_mask = n_valid;
        n_res.tag_name_start    = n_valid[S_TAG]   ? 32'(n_begin[S_TAG])   : '0;
        n_res.tag_name_length   = n_valid[S_TAG]   ? 32'(n_size[S_TAG])    : '0;
        n_res.attr_name_start   = n_valid[S_ANAME] ? 32'(n_begin[S_ANAME]) : '0;
        n_res.attr_name_length  = n_valid[S_ANAME] ? 32'(n_size[S_ANAME])  : '0;
        n_res.attr_value_start  = n_valid[S_AVAL]  ? 32'(n_begin[S_AVAL])  : '0;
        n_res.attr_value_length = n_valid[S_AVAL]  ? 32'(n_size[S_AVAL])   : '0;
        n_res.text_kind   = tk;
        n_res.text_start  = n_valid[tsel] ? 32'(n_begin[tsel]) : '0;
        n_res.text_length = n_valid[tsel] ? 32'(n_size[tsel])  : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx       <= C_NONE;
            r_sc        <= 1'b0;
            r_qf        <= 1'b0;
            r_vu        <= 1'b0;
            r_ltk       <= T_COMMENT;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (tok_take) begin
                r_ctx       <= st.ctx;
                r_sc        <= st.sc;
                r_qf        <= st.qf;
                r_vu        <= st.vu;
                r_ltk       <= st.ltk;
                r_valid     <= n_valid;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_take) begin
            r_begin <= n_begin;
            r_size  <= n_size;
            r_res   <= n_res;
        end
    end

    a_comment_text_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx == C_COMMENT) |-> (r_ltk == T_COMMENT))
        else $error("comment context without comment as last text span");

    a_cdata_text_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx == C_CDATA) |-> (r_ltk == T_CDATA))
        else $error("cdata context without cdata as last text span");

    a_qval_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx == C_QVAL) |-> r_qf)
        else $error("quoted value context with quoted flag clear");

    a_grow_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok_take && st.grow_en) |=> r_valid[$past(st.grow_sel)])
        else $error("grown span not marked valid");

endmodule

@@ src/html_token_context_tracker.sv @@
// A token accepted at the input is written into the queue; the back stage takes it from
// the queue head and registers its snapshot in the output register that drives o_out.
// Throughput: one token per cycle unless the output stalls; the context chain of up to
// four passes and the span growth adders sit in the back stage, a two-beat queue
// parts the stage from the input. The output register takes a new beat in the cycle its
// current one is taken. Reset (synchronous, active low) empties the queue and output,
// sets context to none, clears the flags and marks all six spans invalid.
module html_token_context_tracker import tct_pkg::*; #(
    parameter int POS_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_tok_in i_in,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_res    o_out
);

    localparam int QW = $bits(t_tok_cls) + 2 * POS_WIDTH;

    t_tok_cls             f_cls;
    logic [POS_WIDTH-1:0] f_pos;
    logic [POS_WIDTH-1:0] f_len;
    logic [QW-1:0]        q_data;
    logic                 q_valid;
    logic                 q_ready;
    t_tok_cls             b_cls;
    logic [POS_WIDTH-1:0] b_pos;
    logic [POS_WIDTH-1:0] b_len;

    tct_front #(.POS_WIDTH(POS_WIDTH)) u_front (
        .i_tok (i_in),
        .o_cls (f_cls),
        .o_pos (f_pos),
        .o_len (f_len)
    );

    tct_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  ({f_cls, f_pos, f_len}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    assign {b_cls, b_pos, b_len} = q_data;

    tct_back #(.POS_WIDTH(POS_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .o_tok_ready (q_ready),
        .i_cls       (b_cls),
        .i_pos       (b_pos),
        .i_len       (b_len),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_res       (o_out)
    );

endmodule

@@ tb/sv/tct_snapshot_checker.sv @@
`timescale 1ns / 1ps

module tct_snapshot_checker import tct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_ready,
    input  t_tok_in i_in,
    input  logic    i_out_valid,
    input  logic    i_out_ready,
    input  t_res    i_out,
    output int      o_mismatches,
    output int      o_pending
);

    // tracker state
    logic [3:0]  ctx;
    logic        closed_seen;
    logic        quoted;
    logic        val_unquoted;
    logic [5:0]  span_ok;
    logic [31:0] span_at  [N_SPANS];
    logic [31:0] span_len [N_SPANS];
    logic [1:0]  text_last;

    t_res snap_q [$];
    int   mismatches = 0;

    function automatic void clear_tracker();
        ctx          = C_NONE;
        closed_seen  = 1'b0;
        quoted       = 1'b0;
        val_unquoted = 1'b0;
        span_ok      = '0;
        text_last    = T_COMMENT;
        for (int i = 0; i < N_SPANS; i++) begin
            span_at[i]  = '0;
            span_len[i] = '0;
        end
    endfunction

    function automatic void note_text(logic [2:0] s);
        logic [2:0] d;
        d = s - S_COMMENT;
        if (s >= S_COMMENT) text_last = d[1:0];
    endfunction

    function automatic void drop_span(logic [2:0] s);
        span_ok[s] = 1'b0;
        note_text(s);
    endfunction

    function automatic void extend_span(logic [2:0] s, logic [31:0] at, logic [31:0] len,
                                        logic same);
        logic [32:0] sum;
        sum = {1'b0, span_len[s]} + {1'b0, len};
        if (!span_ok[s] || !same || (span_at[s] + span_len[s]) != at) begin
            span_at[s]  = at;
            span_len[s] = len;
        end else begin
            span_len[s] = sum[32] ? '1 : sum[31:0];
        end
        span_ok[s] = 1'b1;
        note_text(s);
    endfunction

    // one trip through the context machine; high when the token goes round again
    function automatic logic dispatch_pass(logic [4:0] k, logic [31:0] at, logic [31:0] len,
                                           logic raw);
        logic again;
        again = 1'b0;
        case (ctx)
            C_SOL_OR_NAME: begin
                if (k == K_SOLIDUS) begin
                    ctx = C_TAG_NAME;
                end else begin
                    ctx   = (k == K_TAG_NAME) ? C_TAG_NAME : C_TAG;
                    again = 1'b1;
                end
            end
            C_TAG_NAME: begin
                if (k == K_TAG_NAME) begin
                    extend_span(S_TAG, at, len, 1'b1);
                end else if (k == K_WS) begin
                    ctx = C_TAG;
                end else if (k == K_TAG_CLOSE) begin
                    ctx = C_NONE;
                end else begin
                    ctx   = C_TAG;
                    again = 1'b1;
                end
            end
            C_TAG: begin
                if (k == K_TAG_CLOSE) begin
                    ctx = C_NONE;
                end else if (k == K_SOLIDUS) begin
                    ctx = C_TAG_END;
                end else if (k == K_ATTR_NAME) begin
                    ctx = C_ATTR_NAME;
                    drop_span(S_ANAME);
                    drop_span(S_AVAL);
                    quoted = 1'b0;
                    again  = 1'b1;
                end else if (k == K_Q_START) begin
                    ctx = C_QVAL;
                    drop_span(S_ANAME);
                    drop_span(S_AVAL);
                    quoted = 1'b1;
                end
            end
            C_ATTR_NAME: begin
                if (k == K_ATTR_NAME) begin
                    extend_span(S_ANAME, at, len, 1'b1);
                end else if (k == K_EQUAL) begin
                    ctx = C_WS_OR_VAL;
                end else begin
                    ctx   = (k == K_WS) ? C_WS_OR_EQ : C_TAG;
                    again = 1'b1;
                end
            end
            C_WS_OR_EQ: begin
                if (k == K_EQUAL) begin
                    ctx = C_WS_OR_VAL;
                end else if (k != K_WS) begin
                    ctx   = C_TAG;
                    again = 1'b1;
                end
            end
            C_WS_OR_VAL: begin
                if (k == K_Q_START) begin
                    ctx    = C_QVAL;
                    quoted = 1'b1;
                end else if (k != K_WS) begin
                    ctx   = (k == K_U_VALUE) ? C_UVAL : C_TAG;
                    again = 1'b1;
                end
            end
            C_QVAL: begin
                if (k == K_Q_VALUE) begin
                    extend_span(S_AVAL, at, len, !val_unquoted);
                    val_unquoted = 1'b0;
                end else begin
                    ctx   = C_TAG;
                    again = (k != K_Q_END);
                end
            end
            C_UVAL: begin
                if (k == K_U_VALUE) begin
                    extend_span(S_AVAL, at, len, val_unquoted);
                    val_unquoted = 1'b1;
                end else begin
                    ctx   = C_TAG;
                    again = 1'b1;
                end
            end
            C_TAG_END: begin
                if (k == K_TAG_CLOSE) begin
                    closed_seen = 1'b1;
                    ctx         = C_NONE;
                end else begin
                    ctx   = C_TAG;
                    again = 1'b1;
                end
            end
            C_CDATA: begin
                if (k == K_CD_END) begin
                    ctx = C_NONE;
                end else if (k == K_TEXT) begin
                    extend_span(S_CDATA, at, len, 1'b1);
                end
            end
            C_COMMENT: begin
                if (k == K_COM_END) begin
                    ctx = C_NONE;
                end else if (k == K_TEXT) begin
                    extend_span(S_COMMENT, at, len, 1'b1);
                end
            end
            default: begin
                ctx = C_NONE;
                if (raw && k == K_TEXT) begin
                    extend_span(S_RAW, at, len, 1'b1);
                end else if (k == K_TAG_START) begin
                    closed_seen = 1'b0;
                    ctx         = C_SOL_OR_NAME;
                    drop_span(S_TAG);
                end else if (k == K_COM_START) begin
                    ctx = C_COMMENT;
                    drop_span(S_COMMENT);
                end else if (k == K_CD_START) begin
                    ctx = C_CDATA;
                    drop_span(S_CDATA);
                end
            end
        endcase
        return again;
    endfunction

    function automatic logic [63:0] span_view(logic [2:0] s);
        return span_ok[s] ? {span_at[s], span_len[s]} : 64'd0;
    endfunction

    function automatic t_res track_token(t_tok_in tok);
        t_res       r;
        logic       again;
        logic [1:0] tk;
        logic [2:0] ts;
        int         n;
        again = 1'b1;
        for (n = 0; n < MAX_PASSES && again; n++) begin
            again = dispatch_pass(tok.token_kind, tok.token_start, tok.token_length,
                                  tok.rawtext_mode);
        end
        r.context_code    = (ctx == C_NONE && tok.rawtext_mode) ? C_RAW_NONE : ctx;
        r.tag_flags       = {quoted, closed_seen};
        r.span_valid_mask = span_ok;
        {r.tag_name_start, r.tag_name_length}     = span_view(S_TAG);
        {r.attr_name_start, r.attr_name_length}   = span_view(S_ANAME);
        {r.attr_value_start, r.attr_value_length} = span_view(S_AVAL);
        tk          = (text_last > T_RAW) ? T_COMMENT : text_last;
        ts          = S_COMMENT + {1'b0, tk};
        r.text_kind = tk;
        {r.text_start, r.text_length} = span_view(ts);
        return r;
    endfunction

    task automatic show_field(input string name, input logic [31:0] e, input logic [31:0] g);
        if (e !== g) $display("  %s: expected %h, got %h", name, e, g);
    endtask

    task automatic report_diff(input t_res e, input t_res g);
        $display("%0t: snapshot mismatch", $time);
        show_field("context_code", e.context_code, g.context_code);
        show_field("tag_flags", e.tag_flags, g.tag_flags);
        show_field("span_valid_mask", e.span_valid_mask, g.span_valid_mask);
        show_field("tag_name_start", e.tag_name_start, g.tag_name_start);
        show_field("tag_name_length", e.tag_name_length, g.tag_name_length);
        show_field("attr_name_start", e.attr_name_start, g.attr_name_start);
        show_field("attr_name_length", e.attr_name_length, g.attr_name_length);
        show_field("attr_value_start", e.attr_value_start, g.attr_value_start);
        show_field("attr_value_length", e.attr_value_length, g.attr_value_length);
        show_field("text_kind", e.text_kind, g.text_kind);
        show_field("text_start", e.text_start, g.text_start);
        show_field("text_length", e.text_length, g.text_length);
    endtask

    always @(posedge i_clk) begin : watch
        t_res exp_snap;
        if (!i_rst_n) begin
            clear_tracker();
            snap_q.delete();
        end else begin
            // a snapshot leaving now can never belong to the token entering now
            if (i_out_valid && i_out_ready) begin
                if (snap_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("%0t: snapshot with none due: %h", $time, i_out);
                end else begin
                    exp_snap = snap_q.pop_front();
                    if (i_out !== exp_snap) begin
                        mismatches++;
                        if (mismatches <= 10) report_diff(exp_snap, i_out);
                    end
                end
            end
            if (i_in_valid && i_in_ready) snap_q.push_back(track_token(i_in));
        end
        o_mismatches <= mismatches;
        o_pending    <= snap_q.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tct_pkg::*;

    localparam logic [4:0] K_UNKNOWN = 5'd31;

    localparam int N_RANDOM  = 600;
    localparam int RX_HOLD   = 80;
    localparam int END_WAIT  = 2000;
    localparam int SETTLE    = 10;
    localparam int LIMIT_NS  = 1_000_000;

    // receiver patterns
    localparam int RX_FREE   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_MOSTLY = 3;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    tok_valid  = 1'b0;
    logic    tok_ready;
    t_tok_in tok        = '0;
    logic    snap_valid;
    logic    snap_ready = 1'b0;
    t_res    snap;

    int fail_count;
    int pending;

    int          n_sent     = 0;
    int          burst_left = 0;
    logic [31:0] doc_pos    = '0;
    bit          rx_hold_req = 1'b0;
    int          rx_hold_cnt = 0;
    int          rx_mode     = RX_FREE;
    int unsigned rx_stretch  = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    html_token_context_tracker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (tok_valid),
        .o_in_ready (tok_ready),
        .i_in       (tok),
        .o_out_valid(snap_valid),
        .i_out_ready(snap_ready),
        .o_out      (snap)
    );

    tct_snapshot_checker snap_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tok_valid),
        .i_in_ready  (tok_ready),
        .i_in        (tok),
        .i_out_valid (snap_valid),
        .i_out_ready (snap_ready),
        .i_out       (snap),
        .o_mismatches(fail_count),
        .o_pending   (pending)
    );

    // receiver: random stretches of free flow, jitter and heavy stalls, plus one long hold
    always @(posedge clk) begin
        if (rx_hold_req && rx_hold_cnt < RX_HOLD) begin
            rx_hold_cnt++;
            snap_ready <= 1'b0;
        end else begin
            if (rx_stretch == 0) begin
                rx_mode    = $urandom_range(RX_FREE, RX_MOSTLY);
                rx_stretch = $urandom_range(1, 40);
            end
            rx_stretch--;
            case (rx_mode)
                RX_FREE:   snap_ready <= 1'b1;
                RX_HALF:   snap_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: snap_ready <= ($urandom_range(0, 3) == 0);
                default:   snap_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic offer(input t_tok_in t);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                tok_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        tok_valid <= 1'b1;
        tok       <= t;
        @(posedge clk);
        while (!tok_ready) @(posedge clk);
        burst_left--;
        n_sent++;
    endtask

    // token laid at the document cursor
    task automatic put(input logic [4:0] kind, input logic [31:0] len, input logic raw);
        t_tok_in t;
        t.token_kind   = kind;
        t.token_start  = doc_pos;
        t.token_length = len;
        t.rawtext_mode = raw;
        doc_pos        = doc_pos + len;
        offer(t);
    endtask

    // mostly contiguous, now and then a jump or a huge length
    task automatic emit(input logic [4:0] kind, input logic raw);
        logic [31:0] len;
        if ($urandom_range(0, 7) == 0) doc_pos = $urandom;
        if ($urandom_range(0, 7) == 0) len = $urandom | 32'h8000_0000;
        else if ($urandom_range(0, 15) == 0) len = $urandom;
        else len = $urandom_range(0, 16);
        put(kind, len, raw);
    endtask

    task automatic drain();
        tok_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic random_attr(input logic raw);
        int unsigned i, n;
        if ($urandom_range(0, 1) == 1) emit(K_WS, raw);
        if ($urandom_range(0, 7) == 0) begin
            // quoted value with no attribute name before it
            emit(K_Q_START, raw);
            emit(K_Q_VALUE, raw);
            emit(K_Q_END, raw);
        end
        n = $urandom_range(1, 2);
        for (i = 0; i < n; i++) emit(K_ATTR_NAME, raw);
        if ($urandom_range(0, 2) == 0) emit(K_WS, raw);
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                emit(K_EQUAL, raw);
                if ($urandom_range(0, 2) == 0) emit(K_WS, raw);
                emit(K_Q_START, raw);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) emit(K_Q_VALUE, raw);
                if ($urandom_range(0, 7) != 0) emit(K_Q_END, raw);
            end
            2: begin
                emit(K_EQUAL, raw);
                if ($urandom_range(0, 2) == 0) emit(K_WS, raw);
                n = $urandom_range(1, 2);
                for (i = 0; i < n; i++) emit(K_U_VALUE, raw);
            end
            default: begin
                emit(K_EQUAL, raw);
                emit($urandom_range(0, 1) == 1 ? K_Q_VALUE : K_OTHER, raw);
            end
        endcase
    endtask

    task automatic text_block(input logic [4:0] open_k, input logic [4:0] close_k,
                              input logic raw);
        int unsigned i, n;
        emit(open_k, raw);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0:       emit(K_WS, raw);
                1:       emit(K_OTHER, raw);
                default: emit(K_TEXT, raw);
            endcase
        end
        if ($urandom_range(0, 7) != 0) emit(close_k, raw);
    endtask

    task automatic random_sequence();
        int unsigned pick, i, n;
        logic        raw;
        logic [31:0] r;
        pick = $urandom_range(0, 99);
        raw  = ($urandom_range(0, 9) == 0);
        if (pick < 45) begin
            emit(K_TAG_START, raw);
            if ($urandom_range(0, 3) == 0) emit(K_SOLIDUS, raw);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) emit(K_TAG_NAME, raw);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) random_attr(raw);
            if ($urandom_range(0, 3) == 0) emit(K_WS, raw);
            if ($urandom_range(0, 4) == 0) emit(K_SOLIDUS, raw);
            emit(K_TAG_CLOSE, raw);
        end else if (pick < 60) begin
            text_block(K_COM_START, K_COM_END, raw);
        end else if (pick < 70) begin
            text_block(K_CD_START, K_CD_END, raw);
        end else if (pick < 82) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) emit(K_TEXT, $urandom_range(0, 7) != 0);
        end else begin
            // broken or junk sequences
            if ($urandom_range(0, 1) == 1) emit(K_TAG_START, raw);
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                r = $urandom;
                if (r[7]) emit(K_TAG_START + r[4:0] % 11, r[8]);
                else emit(r[4:0], r[8]);
            end
        end
    endtask

    initial begin
        #(LIMIT_NS);
        $display("FAIL html_token_context_tracker");
        $finish;
    end

    initial begin : stimulus
        int n_base;
        int wait_cnt;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // raw text span wrapping past the top of the offset range, then saturating
        doc_pos = 32'hFFFF_FFF0;
        put(K_TEXT, 32'h0000_0010, 1'b1);
        put(K_TEXT, 32'hFFFF_FFFF, 1'b1);
        put(K_TEXT, 32'd5, 1'b0);
        put(K_UNKNOWN, 32'h8000_0000, 1'b1);
        doc_pos = 32'h0000_1000;
        put(K_COM_START, 32'd4, 1'b0);
        put(K_TEXT, 32'd7, 1'b0);
        put(K_TEXT, 32'd3, 1'b0);
        put(K_OTHER, 32'd1, 1'b0);
        put(K_COM_END, 32'd3, 1'b0);
        put(K_CD_START, 32'd9, 1'b0);
        put(K_TEXT, 32'd2, 1'b0);
        put(K_CD_END, 32'd3, 1'b0);
        put(K_TAG_START, 32'd1, 1'b0);
        put(K_SOLIDUS, 32'd1, 1'b0);
        put(K_TAG_NAME, 32'd2, 1'b0);
        put(K_TAG_NAME, 32'd3, 1'b0);
        put(K_WS, 32'd1, 1'b0);
        put(K_ATTR_NAME, 32'd4, 1'b0);
        put(K_WS, 32'd1, 1'b0);
        put(K_EQUAL, 32'd1, 1'b0);
        put(K_Q_START, 32'd1, 1'b0);
        put(K_Q_VALUE, 32'd6, 1'b0);
        put(K_Q_END, 32'd1, 1'b0);
        put(K_ATTR_NAME, 32'd2, 1'b0);
        put(K_EQUAL, 32'd1, 1'b0);
        put(K_U_VALUE, 32'd3, 1'b0);
        put(K_SOLIDUS, 32'd1, 1'b0);
        put(K_TAG_CLOSE, 32'd1, 1'b1);
        drain();

        // long output hold while the sender keeps pushing
        rx_hold_req = 1'b1;
        n_base = n_sent;
        while (n_sent < n_base + N_RANDOM) random_sequence();

        tok_valid <= 1'b0;
        @(posedge clk);
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < END_WAIT) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS html_token_context_tracker");
        end else begin
            $display("FAIL html_token_context_tracker");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/tct_pkg.sv
src/tct_front.sv
src/tct_fifo.sv
src/tct_back.sv
src/html_token_context_tracker.sv
tb/sv/tct_snapshot_checker.sv
tb/sv/tb_top.sv
